[design/ssr_pkg.sv]
// ---------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the substring search-and-replace block.
// ---------------------------------------------------------------------------
package ssr_pkg;

    // Hard limit on the window and on the pattern and replacement storage
    localparam int WIN_DEPTH       = 16;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int REPLACE_MAX_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int POS_W      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_PATTERN_LEN  = 3'd2,
        CFG_REPLACE_LOW  = 3'd3,
        CFG_REPLACE_HIGH = 3'd4,
        CFG_REPLACE_LEN  = 3'd5
    } cfg_idx_t;

    // One request of work handed from the front to the back
    typedef struct packed {
        logic                           head_vld;   // emit head_byte first
        logic [7:0]                     head_byte;
        logic                           rep;        // emit the replacement run
        logic [LEN_W-1:0]               flush_cnt;  // window bytes to flush
        logic [WIN_DEPTH-1:0][7:0]      flush_bytes;
        logic                           last;       // ends the text
    } job_t;

endpackage

[design/ssr_front.sv]
// ---------------------------------------------------------------------------
// ssr_front
// Accept text bytes, maintain the match window and issue at most one job per byte.
// ---------------------------------------------------------------------------
module ssr_front #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       in_last,
    input  logic [8*ssr_pkg::WIN_DEPTH-1:0] pattern,
    input  logic [ssr_pkg::LEN_W-1:0]  plen,
    input  logic [ssr_pkg::LEN_W-1:0]  rlen,
    input  logic                       win_clear,
    input  logic                       q_full,
    output logic                       push,
    output ssr_pkg::job_t              job
);

    localparam int WIN = (PATTERN_MAX < ssr_pkg::WIN_DEPTH) ? PATTERN_MAX : ssr_pkg::WIN_DEPTH;

    logic [7:0]                win_reg  [WIN];
    logic [7:0]                win_next [WIN];
    logic [7:0]                w1       [WIN];
    logic [ssr_pkg::LEN_W-1:0] cnt_reg, cnt_next;
    logic [ssr_pkg::LEN_W-1:0] c1, c2;
    logic                      full, eq, match, accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        full = (plen != '0) && (cnt_reg >= plen);
        c1   = full ? (plen - 1'b1) : cnt_reg;
        for (int i = 0; i < WIN; i++)
        begin
            w1[i] = win_reg[i];
        end
        // drop the oldest byte when the window is full
        if (full)
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                w1[i] = win_reg[i+1];
            end
        end
        for (int i = 0; i < WIN; i++)
        begin
            if (ssr_pkg::LEN_W'(i) == c1)
            begin
                w1[i] = in_byte;
            end
        end
        c2 = c1 + 1'b1;
        eq = 1'b1;
        for (int i = 0; i < WIN; i++)
        begin
            if ((ssr_pkg::LEN_W'(i) < plen) && (w1[i] != pattern[8*i +: 8]))
            begin
                eq = 1'b0;
            end
        end
        match = (plen != '0) && (c2 == plen) && eq;

        job.head_vld  = (plen == '0) || full;
        job.head_byte = (plen == '0) ? in_byte : win_reg[0];
        job.rep       = match;
        job.flush_cnt = (in_last && (plen != '0) && !match) ? c2 : '0;
        job.flush_bytes = '0;
        for (int i = 0; i < WIN; i++)
        begin
            job.flush_bytes[i] = w1[i];
        end
        job.last = in_last;

        push = accept && ((plen == '0) || full || (match && (rlen != '0)) || in_last);

        for (int i = 0; i < WIN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        cnt_next = cnt_reg;
        if (accept)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                win_next[i] = w1[i];
            end
            cnt_next = ((plen == '0) || match || in_last) ? '0 : c2;
        end
        if (win_clear)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

[design/ssr_queue.sv]
// ---------------------------------------------------------------------------
// ssr_queue
// Two-entry job queue between front and back.
// ---------------------------------------------------------------------------
module ssr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssr_pkg::job_t push_job,
    input  logic          pop,
    output ssr_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    ssr_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/ssr_back.sv]
// ---------------------------------------------------------------------------
// ssr_back
// Step through the queued job and emit one result per cycle while a job is queued and out_ready allows.
// ---------------------------------------------------------------------------
module ssr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssr_pkg::job_t               job,
    input  logic                        q_empty,
    output logic                        pop,
    input  logic [8*ssr_pkg::WIN_DEPTH-1:0] replace,
    input  logic [ssr_pkg::LEN_W-1:0]   rlen,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        has_char,
    output logic                        out_last
);

    logic [ssr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [ssr_pkg::POS_W-1:0] total, rep_n, k, fidx;
    logic                      valid_reg, valid_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      has_reg, has_next;
    logic                      last_reg, last_next;
    logic                      advance, done;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign has_char  = has_reg;
    assign out_last  = last_reg;

    assign advance = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        rep_n = job.rep ? ssr_pkg::POS_W'(rlen) : '0;
        total = ssr_pkg::POS_W'(job.head_vld) + rep_n + ssr_pkg::POS_W'(job.flush_cnt);
        k     = pos_reg - ssr_pkg::POS_W'(job.head_vld);
        fidx  = k - rep_n;
        done  = (total == '0) || (pos_reg == total - 1'b1);

        priority if (total == '0)
        begin
            byte_next = '0;    // bare end mark
        end
        else if (job.head_vld && (pos_reg == '0))
        begin
            byte_next = job.head_byte;
        end
        else if (k < rep_n)
        begin
            byte_next = replace[8*k[3:0] +: 8];
        end
        else
        begin
            byte_next = job.flush_bytes[fidx[3:0]];
        end
        has_next  = (total != '0);
        last_next = job.last && done;

        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (advance)
        begin
            valid_next = 1'b1;
        end

        pos_next = pos_reg;
        pop      = 1'b0;
        if (advance)
        begin
            if (done)
            begin
                pos_next = '0;
                pop      = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_next;
            has_reg  <= has_next;
            last_reg <= last_next;
        end
    end

endmodule

[design/substring_search_replace.sv]
// ---------------------------------------------------------------------------
// substring_search_replace
// Streaming search-and-replace over a byte text with a last flag.
// ---------------------------------------------------------------------------
// Bytes enter on s_axis one per request, tlast marking the end of a text. Every
// leftmost, non-overlapping occurrence of the configured pattern is replaced by
// the configured replacement; all other bytes leave on m_axis in order, with a
// delay of up to the pattern length in bytes while they are held in the window.
// m_axis_tuser is 1 when tdata carries a byte and 0 for a bare end mark, sent only
// when the last input byte yields no byte at all; m_axis_tlast marks the final
// result of each text. Rate: the front takes one byte per cycle while the queue
// is not full; a byte that yields k results holds the output sequencer until it
// has issued all k, stalling while m_axis is not ready: a match yields the
// replacement, the flush at end of text the bytes still held. A two-job queue
// lets the front keep accepting while the sequencer works through a replacement
// run. With the queue empty, the first result of a byte passes the queue entry
// and the output register before it is offered on m_axis. Program the registers
// between texts only: writing pattern_len discards the window. A zero pattern
// length passes the text through unchanged.
// ---------------------------------------------------------------------------
module substring_search_replace #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
    input  logic                           s_axis_tlast,   // in_last
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tuser,   // [0] has_char
    output logic                           m_axis_tlast,   // out_last
    // register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data
);

    // effective length caps: the storage never exceeds WIN_DEPTH bytes
    localparam int PCAP = (PATTERN_MAX < ssr_pkg::WIN_DEPTH) ? PATTERN_MAX : ssr_pkg::WIN_DEPTH;
    localparam int RCAP = (REPLACE_MAX < ssr_pkg::WIN_DEPTH) ? REPLACE_MAX : ssr_pkg::WIN_DEPTH;

    logic [8*ssr_pkg::WIN_DEPTH-1:0] pattern_reg, replace_reg;
    logic [ssr_pkg::LEN_W-1:0]       plen_cfg_reg, rlen_cfg_reg;
    logic [ssr_pkg::LEN_W-1:0]       plen, rlen;
    logic                            cfg_wr, win_clear;

    logic          push, pop, q_full, q_empty;
    ssr_pkg::job_t push_job, head_job;

    // registers are always writable
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign win_clear = cfg_wr && (cfg_index == ssr_pkg::CFG_PATTERN_LEN);

    // clamp the programmed lengths to what the block can hold
    assign plen = (plen_cfg_reg > ssr_pkg::LEN_W'(PCAP)) ? ssr_pkg::LEN_W'(PCAP) : plen_cfg_reg;
    assign rlen = (rlen_cfg_reg > ssr_pkg::LEN_W'(RCAP)) ? ssr_pkg::LEN_W'(RCAP) : rlen_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            replace_reg  <= '0;
            plen_cfg_reg <= '0;
            rlen_cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                ssr_pkg::CFG_PATTERN_LOW:  pattern_reg[63:0]   <= cfg_data;
                ssr_pkg::CFG_PATTERN_HIGH: pattern_reg[127:64] <= cfg_data;
                ssr_pkg::CFG_PATTERN_LEN:  plen_cfg_reg <= cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::CFG_REPLACE_LOW:  replace_reg[63:0]   <= cfg_data;
                ssr_pkg::CFG_REPLACE_HIGH: replace_reg[127:64] <= cfg_data;
                ssr_pkg::CFG_REPLACE_LEN:  rlen_cfg_reg <= cfg_data[ssr_pkg::LEN_W-1:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // front: window and match decision, one byte per cycle while the queue has room
    ssr_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .pattern   (pattern_reg),
        .plen      (plen),
        .rlen      (rlen),
        .win_clear (win_clear),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    // hold up to two jobs so the front runs ahead of long replacement runs
    ssr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: emit head byte, replacement run and flush, one result per cycle while m_axis is ready
    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .q_empty   (q_empty),
        .pop       (pop),
        .replace   (replace_reg),
        .rlen      (rlen),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .has_char  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
